[hw/rtl/lesc_pkg.sv]
package lesc_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned STEP_W  = 9;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned OHEAD_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_OFF       = 3'd0;
  localparam mode_t MODE_SOLID     = 3'd1;
  localparam mode_t MODE_BREATHING = 3'd2;
  localparam mode_t MODE_COMET     = 3'd3;
  localparam mode_t MODE_RAINBOW   = 3'd4;
  localparam mode_t MODE_LAST      = MODE_RAINBOW;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 8'd199;
  localparam logic [HUE_W-1:0]   HUE_WRAP   = 9'd360;
  localparam logic [HUE_W-1:0]   HUE_STEP   = 9'd2;

  localparam logic [COLOR_W-1:0] COLOR_RST  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd96;
  localparam logic [LEVEL_W-1:0] FLOOR_RST  = 8'd16;
  localparam logic [LEVEL_W-1:0] CEIL_RST   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_FLOOR   = 2'd0,
    REG_LEVEL_CEILING = 2'd1
  } cfg_reg_t;

  // command payload, first field in the highest bits
  typedef struct packed {
    logic                      pad;
    logic signed [STEP_W-1:0]  level_step;
    logic [LEVEL_W-1:0]        new_level;
    logic                      level_valid;
    logic [COLOR_W-1:0]        new_blue;
    logic [COLOR_W-1:0]        new_green;
    logic [COLOR_W-1:0]        new_red;
    logic                      color_set;
    mode_t                     new_mode;
    logic                      mode_set;
  } cmd_data_t;

  // frame result payload, first field in the highest bits
  typedef struct packed {
    logic [6:0]                pad;
    logic                      out_rising;
    logic [OHEAD_W-1:0]        out_head;
    logic [HUE_W-1:0]          out_hue;
    logic [PHASE_W-1:0]        out_phase;
    logic [LEVEL_W-1:0]        out_level;
    logic [COLOR_W-1:0]        out_blue;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_red;
    mode_t                     out_mode;
  } frame_data_t;

endpackage

[hw/rtl/led_effect_state_controller.sv]
// LED strip effect state controller. Each request on the s_ side is either a
// command (s_tuser low: level step clamped to level_floor/level_ceiling, then
// exact level, color and mode) or a frame tick (s_tuser high: report the
// current frame parameters, then advance breathing phase, rainbow hue or comet
// head). Every request yields exactly one result on the m_ side, in the cycle
// after it is taken. One request is taken per cycle: the effect state is
// updated as the request is taken and the result sits in one output register, so
// s_tready only drops while that register holds a result that m_tready has not
// taken. The head position is clog2(LED_COUNT) bits wide internally; out_head
// carries its low four bits. level_floor and level_ceiling are written through
// the cfg_ port at indexes 0 and 1; other indexes are accepted and dropped.
module led_effect_state_controller #(
  parameter int unsigned LED_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mode_set, new_mode, color_set, new_red, new_green, new_blue,
  // level_valid, new_level, level_step, zero pad
  input  lesc_pkg::cmd_data_t           s_tdata,
  // cmd: 0 command, 1 frame tick
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_mode, out_red, out_green, out_blue, out_level, out_phase, out_hue,
  // out_head, out_rising, zero pad
  output lesc_pkg::frame_data_t         m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lesc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lesc_pkg::LEVEL_W-1:0]   cfg_data
);
  import lesc_pkg::*;

  localparam int unsigned HEAD_W = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(LED_COUNT - 1);

  logic [LEVEL_W-1:0] level_floor;
  logic [LEVEL_W-1:0] level_ceiling;

  mode_t              cur_mode;
  logic [COLOR_W-1:0] cur_red;
  logic [COLOR_W-1:0] cur_green;
  logic [COLOR_W-1:0] cur_blue;
  logic [LEVEL_W-1:0] cur_level;
  logic [PHASE_W-1:0] breath_phase;
  logic [HUE_W-1:0]   hue_angle;
  logic [HEAD_W-1:0]  head_pos;
  logic               head_rising;

  mode_t              cur_mode_next;
  logic [COLOR_W-1:0] cur_red_next;
  logic [COLOR_W-1:0] cur_green_next;
  logic [COLOR_W-1:0] cur_blue_next;
  logic [LEVEL_W-1:0] cur_level_next;
  logic [PHASE_W-1:0] breath_phase_next;
  logic [HUE_W-1:0]   hue_angle_next;
  logic [HEAD_W-1:0]  head_pos_next;
  logic               head_rising_next;

  logic               in_fire;
  logic               out_fire;
  logic               is_tick;
  logic signed [LEVEL_W+2:0] level_sum;
  logic [HUE_W-1:0]   hue_sum;
  logic [HEAD_W:0]    head_inc;
  logic               mode_take;
  frame_data_t        frame;
  logic [HEAD_W+OHEAD_W-1:0] head_ext;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign is_tick  = s_tuser;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_floor   <= FLOOR_RST;
      level_ceiling <= CEIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEVEL_FLOOR:   level_floor   <= cfg_data;
        REG_LEVEL_CEILING: level_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  assign level_sum = $signed({3'b000, cur_level}) +
                     $signed({{2{s_tdata.level_step[STEP_W-1]}}, s_tdata.level_step});
  assign hue_sum   = hue_angle + HUE_STEP;
  assign head_inc  = {1'b0, head_pos} + (HEAD_W+1)'(1);
  assign mode_take = s_tdata.mode_set && (s_tdata.new_mode <= MODE_LAST);

  always_comb begin
    cur_mode_next     = cur_mode;
    cur_red_next      = cur_red;
    cur_green_next    = cur_green;
    cur_blue_next     = cur_blue;
    cur_level_next    = cur_level;
    breath_phase_next = breath_phase;
    hue_angle_next    = hue_angle;
    head_pos_next     = head_pos;
    head_rising_next  = head_rising;

    if (is_tick) begin
      priority if (cur_mode == MODE_BREATHING) begin
        breath_phase_next = (breath_phase == PHASE_LAST) ? '0 : breath_phase + 1'b1;
      end else if (cur_mode == MODE_RAINBOW) begin
        hue_angle_next = (hue_sum >= HUE_WRAP) ? hue_sum - HUE_WRAP : hue_sum;
      end else if (cur_mode == MODE_COMET) begin
        if (head_rising) begin
          if (head_inc >= {1'b0, HEAD_LAST}) begin
            head_pos_next    = HEAD_LAST;
            head_rising_next = 1'b0;
          end else begin
            head_pos_next = head_inc[HEAD_W-1:0];
          end
        end else begin
          if (head_pos <= HEAD_W'(1)) begin
            head_pos_next    = '0;
            head_rising_next = 1'b1;
          end else begin
            head_pos_next = head_pos - 1'b1;
          end
        end
      end else begin
      end
    end else begin
      // floor is tested before ceiling; a zero step leaves the level alone
      if (s_tdata.level_step != '0) begin
        priority if (level_sum < $signed({3'b000, level_floor})) begin
          cur_level_next = level_floor;
        end else if (level_sum > $signed({3'b000, level_ceiling})) begin
          cur_level_next = level_ceiling;
        end else begin
          cur_level_next = level_sum[LEVEL_W-1:0];
        end
      end
      if (s_tdata.level_valid) begin
        cur_level_next = s_tdata.new_level;
      end
      if (s_tdata.color_set) begin
        cur_red_next   = s_tdata.new_red;
        cur_green_next = s_tdata.new_green;
        cur_blue_next  = s_tdata.new_blue;
      end
      if (mode_take) begin
        cur_mode_next = s_tdata.new_mode;
        if (s_tdata.new_mode != cur_mode) begin
          breath_phase_next = '0;
          hue_angle_next    = '0;
          head_pos_next     = '0;
          head_rising_next  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode     <= MODE_OFF;
      cur_red      <= COLOR_RST;
      cur_green    <= COLOR_RST;
      cur_blue     <= COLOR_RST;
      cur_level    <= LEVEL_RST;
      breath_phase <= '0;
      hue_angle    <= '0;
      head_pos     <= '0;
      head_rising  <= 1'b1;
    end else if (in_fire) begin
      cur_mode     <= cur_mode_next;
      cur_red      <= cur_red_next;
      cur_green    <= cur_green_next;
      cur_blue     <= cur_blue_next;
      cur_level    <= cur_level_next;
      breath_phase <= breath_phase_next;
      hue_angle    <= hue_angle_next;
      head_pos     <= head_pos_next;
      head_rising  <= head_rising_next;
    end
  end

  // a tick reports the counters from before its advance, a command after
  assign head_ext = {{OHEAD_W{1'b0}}, is_tick ? head_pos : head_pos_next};

  always_comb begin
    frame            = '0;
    frame.out_mode   = cur_mode_next;
    frame.out_red    = cur_red_next;
    frame.out_green  = cur_green_next;
    frame.out_blue   = cur_blue_next;
    frame.out_level  = cur_level_next;
    frame.out_phase  = is_tick ? breath_phase : breath_phase_next;
    frame.out_hue    = is_tick ? hue_angle : hue_angle_next;
    frame.out_head   = head_ext[OHEAD_W-1:0];
    frame.out_rising = is_tick ? head_rising : head_rising_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= frame;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    breath_phase <= PHASE_LAST) else $error("breathing phase out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (hue_angle < HUE_WRAP) && !hue_angle[0]) else $error("hue out of range or odd");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head_pos <= HEAD_LAST) else $error("comet head beyond last LED");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost or overwritten");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_tick && (cur_mode == MODE_OFF || cur_mode == MODE_SOLID)
    |=> $stable(breath_phase) && $stable(hue_angle) && $stable(head_pos))
    else $error("static mode tick moved the animation");

endmodule
